// File: design/abos_pkg.sv
// Shared types, constants and helpers for the adjacent box overlap suppression block.
package abos_pkg;

  localparam int COORD_BITS    = 12;
  localparam int SCORE_BITS    = 16;
  localparam int CLASS_BITS    = 8;
  localparam int PCT_BITS      = 7;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = SCORE_BITS;

  // Area products are 2*COORD_BITS wide, union one more, scaled by a percent.
  localparam int AREA_BITS  = 2 * COORD_BITS;
  localparam int UNION_BITS = AREA_BITS + 1;
  localparam int PROD_BITS  = UNION_BITS + PCT_BITS;
  localparam int MUL_STEPS  = COORD_BITS;
  localparam int CNT_BITS   = $clog2(MUL_STEPS);

  localparam logic [CFG_IDX_BITS-1:0] REG_TOL_HIGH   = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_TOL_LOW    = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_TOL_ONE    = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_WEAK_SCORE = 2'd3;

  localparam logic [PCT_BITS-1:0]   TOL_HIGH_RESET   = 7'd40;
  localparam logic [PCT_BITS-1:0]   TOL_LOW_RESET    = 7'd30;
  localparam logic [PCT_BITS-1:0]   TOL_ONE_RESET    = 7'd60;
  localparam logic [SCORE_BITS-1:0] WEAK_SCORE_RESET = 16'd13107;

  localparam logic [CLASS_BITS-1:0] CHAR_ONE   = 8'h31;
  localparam logic [CLASS_BITS-1:0] CHAR_SEVEN = 8'h37;
  localparam logic [CLASS_BITS-1:0] CHAR_FOUR  = 8'h34;
  localparam logic [CLASS_BITS-1:0] CHAR_H     = 8'h48;

  typedef struct packed {
    logic [COORD_BITS-1:0] box_x;
    logic [COORD_BITS-1:0] box_y;
    logic [COORD_BITS-1:0] box_w;
    logic [COORD_BITS-1:0] box_h;
    logic [SCORE_BITS-1:0] score;
    logic [CLASS_BITS-1:0] class_code;
    logic                  last;
  } det_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] out_x;
    logic [COORD_BITS-1:0] out_y;
    logic [COORD_BITS-1:0] out_w;
    logic [COORD_BITS-1:0] out_h;
    logic [SCORE_BITS-1:0] out_score;
    logic [CLASS_BITS-1:0] out_class;
    logic                  out_last;
  } surv_t;

  typedef enum logic [11:0] {
    ST_IDLE   = 12'b0000_0000_0001,
    ST_OVL    = 12'b0000_0000_0010,
    ST_INTER  = 12'b0000_0000_0100,
    ST_AREA_H = 12'b0000_0000_1000,
    ST_AREA_N = 12'b0000_0001_0000,
    ST_UNION  = 12'b0000_0010_0000,
    ST_MUL_TH = 12'b0000_0100_0000,
    ST_MUL_TL = 12'b0000_1000_0000,
    ST_DECIDE = 12'b0001_0000_0000,
    ST_EMIT   = 12'b0010_0000_0000,
    ST_UPDATE = 12'b0100_0000_0000,
    ST_FLUSH  = 12'b1000_0000_0000
  } state_t;

  // One class is a digit one and the other cannot be mistaken for it.
  function automatic logic plain_one(input logic [CLASS_BITS-1:0] a,
                                     input logic [CLASS_BITS-1:0] b);
    return (a == CHAR_ONE) && (b != CHAR_SEVEN) && (b != CHAR_FOUR) && (b != CHAR_H);
  endfunction

endpackage

// File: design/abos_ifs.sv
// Valid/ready channel interfaces for detections and surviving boxes.
interface abos_det_if import abos_pkg::*; ();
  logic valid;
  logic ready;
  det_t item;
  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

interface abos_surv_if import abos_pkg::*; ();
  logic  valid;
  logic  ready;
  surv_t item;
  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

// File: design/adjacent_box_overlap_suppression_top.sv
// Adjacent box overlap suppression: held box versus new box by exact IoU tolerance.
// Items are taken one at a time: a new item is accepted only in the idle state, once the
//   last is done. With a held box, the work is five 12-step bit-serial shift-add multiplies
//   on one shared unit; with an empty hold the item goes straight to the update. Output
//   back-pressure can stall the emit and flush states.
// Reset (synchronous, rst high): empties the hold and output register, loads register defaults.
module adjacent_box_overlap_suppression_top import abos_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_write,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data,
  abos_det_if.sink                 detection,
  abos_surv_if.source              survivor
);

  state_t state;

  logic [PCT_BITS-1:0]   tol_high_pct;
  logic [PCT_BITS-1:0]   tol_low_pct;
  logic [PCT_BITS-1:0]   tol_one_pct;
  logic [SCORE_BITS-1:0] weak_score;

  logic                  held_valid;
  logic [COORD_BITS-1:0] held_x, held_y, held_w, held_h;
  logic [SCORE_BITS-1:0] held_score;
  logic [CLASS_BITS-1:0] held_class;

  det_t  n_item;
  surv_t out_r;
  logic  out_valid;
  logic  emit_held;
  logic  take_new;
  logic  load_out;

  // Shared shift-add multiplier
  logic [PROD_BITS-1:0]  mcand;
  logic [COORD_BITS-1:0] mplier;
  logic [PROD_BITS-1:0]  acc;
  logic [CNT_BITS-1:0]   cnt;
  logic [PROD_BITS-1:0]  acc_sum;
  logic                  mul_done;

  logic [AREA_BITS-1:0]  inter;
  logic [UNION_BITS-1:0] area_sum;
  logic [UNION_BITS-1:0] uni;
  logic [UNION_BITS-1:0] uni_val;
  logic [PROD_BITS-1:0]  lhs;
  logic [PROD_BITS-1:0]  lhs_base;
  logic [PROD_BITS-1:0]  pth;
  logic [PROD_BITS-1:0]  ptl;

  logic                  one;
  logic [PCT_BITS-1:0]   th_sel;
  logic [PCT_BITS-1:0]   tl_sel;
  logic [COORD_BITS-1:0] ovl_x, ovl_y;
  logic                  slot_free;
  logic                  mul_state;

  logic over_hi, over_lo, held_lower, new_lower, held_weak, new_weak;
  logic drop_held, drop_new;

  function automatic logic [COORD_BITS-1:0] span_overlap(
    input logic [COORD_BITS-1:0] a0, input logic [COORD_BITS-1:0] al,
    input logic [COORD_BITS-1:0] b0, input logic [COORD_BITS-1:0] bl);
    logic [COORD_BITS:0] lo;
    logic [COORD_BITS:0] hi;
    logic [COORD_BITS:0] ae;
    logic [COORD_BITS:0] be;
    logic [COORD_BITS:0] diff;
    lo = (a0 > b0) ? {1'b0, a0} : {1'b0, b0};
    ae = {1'b0, a0} + {1'b0, al};
    be = {1'b0, b0} + {1'b0, bl};
    hi = (ae < be) ? ae : be;
    diff = hi - lo;
    return (hi > lo) ? diff[COORD_BITS-1:0] : '0;
  endfunction

  always_comb begin
    detection.ready = (state == ST_IDLE);
    survivor.valid  = out_valid;
    survivor.item   = out_r;
    slot_free       = !out_valid || survivor.ready;
    load_out        = ((state == ST_EMIT) && emit_held && slot_free) ||
                      ((state == ST_FLUSH) && n_item.last && held_valid && slot_free);

    one    = plain_one(held_class, n_item.class_code) || plain_one(n_item.class_code, held_class);
    th_sel = one ? tol_one_pct : tol_high_pct;
    tl_sel = one ? tol_one_pct : tol_low_pct;

    ovl_x = span_overlap(held_x, held_w, n_item.box_x, n_item.box_w);
    ovl_y = span_overlap(held_y, held_h, n_item.box_y, n_item.box_h);

    mul_state = (state == ST_INTER) || (state == ST_AREA_H) || (state == ST_AREA_N) ||
                (state == ST_MUL_TH) || (state == ST_MUL_TL);
    acc_sum   = acc + (mplier[0] ? mcand : '0);
    mul_done  = (cnt == CNT_BITS'(MUL_STEPS - 1));

    uni_val  = area_sum - {1'b0, inter};
    lhs_base = PROD_BITS'(inter);

    over_hi    = lhs > pth;
    over_lo    = lhs > ptl;
    held_lower = held_score < n_item.score;
    new_lower  = n_item.score < held_score;
    held_weak  = held_score < weak_score;
    new_weak   = n_item.score < weak_score;
    drop_held  = over_hi ? held_lower : (over_lo && held_lower && held_weak);
    drop_new   = over_hi ? !held_lower
                         : (over_lo && !(held_lower && held_weak) && new_lower && new_weak);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      out_valid    <= 1'b0;
      held_valid   <= 1'b0;
      tol_high_pct <= TOL_HIGH_RESET;
      tol_low_pct  <= TOL_LOW_RESET;
      tol_one_pct  <= TOL_ONE_RESET;
      weak_score   <= WEAK_SCORE_RESET;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          REG_TOL_HIGH:   tol_high_pct <= cfg_data[PCT_BITS-1:0];
          REG_TOL_LOW:    tol_low_pct  <= cfg_data[PCT_BITS-1:0];
          REG_TOL_ONE:    tol_one_pct  <= cfg_data[PCT_BITS-1:0];
          REG_WEAK_SCORE: weak_score   <= cfg_data[SCORE_BITS-1:0];
          default:        ;
        endcase
      end

      if (load_out) begin
        out_valid <= 1'b1;
      end else if (survivor.valid && survivor.ready) begin
        out_valid <= 1'b0;
      end

      // One multiplier bit per cycle
      if (mul_state && !mul_done) begin
        acc    <= acc_sum;
        mcand  <= mcand << 1;
        mplier <= mplier >> 1;
        cnt    <= cnt + 1'b1;
      end

      unique case (state)
        ST_IDLE: begin
          if (detection.valid) begin
            n_item    <= detection.item;
            emit_held <= 1'b0;
            take_new  <= 1'b1;
            state     <= held_valid ? ST_OVL : ST_UPDATE;
          end
        end
        ST_OVL: begin
          mcand  <= PROD_BITS'(ovl_x);
          mplier <= ovl_y;
          acc    <= '0;
          cnt    <= '0;
          state  <= ST_INTER;
        end
        ST_INTER: begin
          if (mul_done) begin
            inter  <= acc_sum[AREA_BITS-1:0];
            mcand  <= PROD_BITS'(held_w);
            mplier <= held_h;
            acc    <= '0;
            cnt    <= '0;
            state  <= ST_AREA_H;
          end
        end
        ST_AREA_H: begin
          if (mul_done) begin
            area_sum <= UNION_BITS'(acc_sum[AREA_BITS-1:0]);
            mcand    <= PROD_BITS'(n_item.box_w);
            mplier   <= n_item.box_h;
            acc      <= '0;
            cnt      <= '0;
            state    <= ST_AREA_N;
          end
        end
        ST_AREA_N: begin
          if (mul_done) begin
            area_sum <= area_sum + UNION_BITS'(acc_sum[AREA_BITS-1:0]);
            state    <= ST_UNION;
          end
        end
        ST_UNION: begin
          uni    <= uni_val;
          // times 100 as 64 + 32 + 4
          lhs    <= (lhs_base << 6) + (lhs_base << 5) + (lhs_base << 2);
          mcand  <= PROD_BITS'(uni_val);
          mplier <= COORD_BITS'(th_sel);
          acc    <= '0;
          cnt    <= '0;
          state  <= ST_MUL_TH;
        end
        ST_MUL_TH: begin
          if (mul_done) begin
            pth    <= acc_sum;
            mcand  <= PROD_BITS'(uni);
            mplier <= COORD_BITS'(tl_sel);
            acc    <= '0;
            cnt    <= '0;
            state  <= ST_MUL_TL;
          end
        end
        ST_MUL_TL: begin
          if (mul_done) begin
            ptl   <= acc_sum;
            state <= ST_DECIDE;
          end
        end
        ST_DECIDE: begin
          emit_held <= !drop_new && !drop_held;
          take_new  <= !drop_new;
          state     <= ST_EMIT;
        end
        ST_EMIT: begin
          if (!emit_held) begin
            state <= ST_UPDATE;
          end else if (slot_free) begin
            out_r.out_x     <= held_x;
            out_r.out_y     <= held_y;
            out_r.out_w     <= held_w;
            out_r.out_h     <= held_h;
            out_r.out_score <= held_score;
            out_r.out_class <= held_class;
            out_r.out_last  <= 1'b0;
            state           <= ST_UPDATE;
          end
        end
        ST_UPDATE: begin
          if (take_new) begin
            held_valid <= 1'b1;
            held_x     <= n_item.box_x;
            held_y     <= n_item.box_y;
            held_w     <= n_item.box_w;
            held_h     <= n_item.box_h;
            held_score <= n_item.score;
            held_class <= n_item.class_code;
          end
          state <= ST_FLUSH;
        end
        ST_FLUSH: begin
          if (!(n_item.last && held_valid)) begin
            state <= ST_IDLE;
          end else if (slot_free) begin
            out_r.out_x     <= held_x;
            out_r.out_y     <= held_y;
            out_r.out_w     <= held_w;
            out_r.out_h     <= held_h;
            out_r.out_score <= held_score;
            out_r.out_class <= held_class;
            out_r.out_last  <= 1'b1;
            held_valid      <= 1'b0;
            state           <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// File: design/abos_check.sv
// Port-level checks for the overlap suppression block, bound to its top level.
module abos_check import abos_pkg::*; (
  input logic  clk,
  input logic  rst,
  input logic  det_valid,
  input logic  det_ready,
  input logic  surv_valid,
  input logic  surv_ready,
  input surv_t surv_item
);

  // a stalled result holds
  a_surv_hold: assert property (@(posedge clk) disable iff (rst)
    surv_valid && !surv_ready |=> surv_valid && $stable(surv_item))
    else $error("stalled survivor item changed");

  // one item in work at a time
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    det_valid && det_ready |=> !det_ready)
    else $error("detection accepted while an item is in work");

  a_reset_empty: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !surv_valid)
    else $error("survivor valid right after reset");

endmodule

bind adjacent_box_overlap_suppression_top abos_check u_abos_check (
  .clk        (clk),
  .rst        (rst),
  .det_valid  (detection.valid),
  .det_ready  (detection.ready),
  .surv_valid (survivor.valid),
  .surv_ready (survivor.ready),
  .surv_item  (survivor.item)
);

// File: tb/tb.sv
// Self-checking bench for adjacent_box_overlap_suppression_top: predicted survivors vs. output.
`timescale 1ns / 100ps

module tb import abos_pkg::*; ();

  localparam int QUIET_LIMIT   = 5000;
  localparam int DRAIN_CYCLES  = 100;
  localparam int PHASE_ITEMS   = 205;
  localparam int NUM_PHASES    = 6;
  localparam int REPORT_LIMIT  = 10;

  logic                     clk;
  logic                     rst;
  logic                     cfg_write;
  logic [CFG_IDX_BITS-1:0]  cfg_index;
  logic [CFG_DATA_BITS-1:0] cfg_data;

  abos_det_if  det_ch ();
  abos_surv_if surv_ch ();

  adjacent_box_overlap_suppression_top dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .detection (det_ch),
    .survivor  (surv_ch)
  );

  // Predictor copy of the registers and of the held box.
  logic [PCT_BITS-1:0]   cut_high   = TOL_HIGH_RESET;
  logic [PCT_BITS-1:0]   cut_low    = TOL_LOW_RESET;
  logic [PCT_BITS-1:0]   cut_one    = TOL_ONE_RESET;
  logic [SCORE_BITS-1:0] weak_limit = WEAK_SCORE_RESET;
  logic                  hold_valid = 1'b0;
  det_t                  hold_box   = '0;

  det_t  detections_to_send[$];
  surv_t survivors_due[$];
  int    mismatches   = 0;
  int    quiet_cycles = 0;
  logic  no_idle      = 1'b0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic logic pause_now();
    return !no_idle && ($urandom_range(99) < 23);
  endfunction

  function automatic logic digit_one_clear(input logic [CLASS_BITS-1:0] a,
                                           input logic [CLASS_BITS-1:0] b);
    return a == CHAR_ONE && b != CHAR_SEVEN && b != CHAR_FOUR && b != CHAR_H;
  endfunction

  function automatic longint unsigned span_overlap(input longint unsigned a0,
                                                   input longint unsigned al,
                                                   input longint unsigned b0,
                                                   input longint unsigned bl);
    longint unsigned lo, hi;
    lo = (a0 > b0) ? a0 : b0;
    hi = (a0 + al < b0 + bl) ? a0 + al : b0 + bl;
    return (hi > lo) ? hi - lo : 64'd0;
  endfunction

  function automatic surv_t held_as_survivor(input logic fin);
    surv_t s;
    s.out_x     = hold_box.box_x;
    s.out_y     = hold_box.box_y;
    s.out_w     = hold_box.box_w;
    s.out_h     = hold_box.box_h;
    s.out_score = hold_box.score;
    s.out_class = hold_box.class_code;
    s.out_last  = fin;
    return s;
  endfunction

  task automatic predict_survivors(input det_t d);
    logic              pair_one, drop_held, drop_new, take_new;
    longint unsigned   th, tl, inter, uni, lhs;
    longint unsigned   hw, hh, nw, nh;
    drop_held = 1'b0;
    drop_new  = 1'b0;
    take_new  = 1'b1;
    if (hold_valid) begin
      pair_one = digit_one_clear(hold_box.class_code, d.class_code) ||
                 digit_one_clear(d.class_code, hold_box.class_code);
      th = pair_one ? 64'(cut_one) : 64'(cut_high);
      tl = pair_one ? 64'(cut_one) : 64'(cut_low);
      hw = 64'(hold_box.box_w);
      hh = 64'(hold_box.box_h);
      nw = 64'(d.box_w);
      nh = 64'(d.box_h);
      inter = span_overlap(64'(hold_box.box_x), hw, 64'(d.box_x), nw) *
              span_overlap(64'(hold_box.box_y), hh, 64'(d.box_y), nh);
      uni = hw * hh + nw * nh - inter;
      lhs = 100 * inter;
      if (lhs > th * uni) begin
        if (hold_box.score < d.score) drop_held = 1'b1;
        else drop_new = 1'b1;
      end else if (lhs > tl * uni) begin
        if (hold_box.score < d.score && hold_box.score < weak_limit) drop_held = 1'b1;
        else if (d.score < hold_box.score && d.score < weak_limit) drop_new = 1'b1;
      end
      if (drop_new) take_new = 1'b0;
      else if (!drop_held)
        survivors_due.insert(survivors_due.size(), held_as_survivor(1'b0));
    end
    if (take_new) begin
      hold_valid = 1'b1;
      hold_box   = d;
    end
    // flush the hold on the final detection of the list
    if (d.last && hold_valid) begin
      survivors_due.insert(survivors_due.size(), held_as_survivor(1'b1));
      hold_valid = 1'b0;
    end
  endtask

  task automatic check_survivor(input surv_t got);
    surv_t want;
    if (survivors_due.size() == 0) begin
      if (mismatches < REPORT_LIMIT)
        $display("unexpected survivor: x=%0d y=%0d w=%0d h=%0d score=%0d class=%0d last=%0b",
                 got.out_x, got.out_y, got.out_w, got.out_h, got.out_score,
                 got.out_class, got.out_last);
      mismatches++;
    end else begin
      want = survivors_due.pop_front();
      if (got.out_x !== want.out_x || got.out_y !== want.out_y ||
          got.out_w !== want.out_w || got.out_h !== want.out_h ||
          got.out_score !== want.out_score || got.out_class !== want.out_class ||
          got.out_last !== want.out_last) begin
        if (mismatches < REPORT_LIMIT) begin
          $display("survivor mismatch: expected x=%0d y=%0d w=%0d h=%0d score=%0d class=%0d last=%0b",
                   want.out_x, want.out_y, want.out_w, want.out_h, want.out_score,
                   want.out_class, want.out_last);
          $display("                   actual   x=%0d y=%0d w=%0d h=%0d score=%0d class=%0d last=%0b",
                   got.out_x, got.out_y, got.out_w, got.out_h, got.out_score,
                   got.out_class, got.out_last);
        end
        mismatches++;
      end
    end
  endtask

  // Detection driver: hold the item until accepted, then advance the queue.
  always @(posedge clk) begin
    if (rst) begin
      det_ch.valid <= 1'b0;
    end else begin
      if (det_ch.valid && det_ch.ready) begin
        predict_survivors(det_ch.item);
        void'(detections_to_send.pop_front());
      end
      if (!(det_ch.valid && !det_ch.ready)) begin
        if (detections_to_send.size() > 0 && !pause_now()) begin
          det_ch.valid <= 1'b1;
          det_ch.item  <= detections_to_send[0];
        end else begin
          det_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Survivor monitor with random back-pressure.
  always @(posedge clk) begin
    if (rst) begin
      surv_ch.ready <= 1'b0;
    end else begin
      if (surv_ch.valid && surv_ch.ready) check_survivor(surv_ch.item);
      surv_ch.ready <= !pause_now();
    end
  end

  always @(posedge clk) begin
    if (rst || (det_ch.valid && det_ch.ready) || (surv_ch.valid && surv_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("FAIL adjacent_box_overlap_suppression_top");
    $finish;
  end

  task automatic write_cfg(input logic [CFG_IDX_BITS-1:0] idx, input int value);
    logic [CFG_DATA_BITS-1:0] data;
    data = CFG_DATA_BITS'($urandom);
    if (idx == REG_WEAK_SCORE) data = CFG_DATA_BITS'(value);
    else data[PCT_BITS-1:0] = PCT_BITS'(value);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      REG_TOL_HIGH:   cut_high   = data[PCT_BITS-1:0];
      REG_TOL_LOW:    cut_low    = data[PCT_BITS-1:0];
      REG_TOL_ONE:    cut_one    = data[PCT_BITS-1:0];
      REG_WEAK_SCORE: weak_limit = data[SCORE_BITS-1:0];
      default: ;
    endcase
  endtask

  task automatic load_settings(input int hi, input int lo, input int one, input int weak_val);
    write_cfg(REG_TOL_HIGH, hi);
    write_cfg(REG_TOL_LOW, lo);
    write_cfg(REG_TOL_ONE, one);
    write_cfg(REG_WEAK_SCORE, weak_val);
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  // Wait until every detection is in and every survivor is out, then let the
  // block finish any item whose boxes were all dropped.
  task automatic wait_drained();
    while (detections_to_send.size() != 0 || det_ch.valid || survivors_due.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic push_det(input int x, input int y, input int w, input int h,
                          input int s, input logic [CLASS_BITS-1:0] c, input logic fin);
    det_t d;
    d.box_x      = COORD_BITS'(x);
    d.box_y      = COORD_BITS'(y);
    d.box_w      = COORD_BITS'(w);
    d.box_h      = COORD_BITS'(h);
    d.score      = SCORE_BITS'(s);
    d.class_code = c;
    d.last       = fin;
    detections_to_send.insert(detections_to_send.size(), d);
  endtask

  function automatic logic [COORD_BITS-1:0] pick_size();
    int r;
    r = $urandom_range(99);
    if (r < 5) return '0;
    if (r < 10) return COORD_BITS'($urandom);
    return COORD_BITS'($urandom_range(1, 64));
  endfunction

  function automatic logic [SCORE_BITS-1:0] pick_score(input logic [SCORE_BITS-1:0] prev);
    int r;
    r = $urandom_range(99);
    if (r < 10) return '0;
    if (r < 20) return '1;
    if (r < 35) return prev;
    if (r < 60) return SCORE_BITS'(int'(weak_limit) + $urandom_range(4) - 2);
    return SCORE_BITS'($urandom);
  endfunction

  function automatic logic [CLASS_BITS-1:0] pick_class();
    int r;
    r = $urandom_range(99);
    if (r < 30) return CHAR_ONE;
    if (r < 38) return CHAR_SEVEN;
    if (r < 46) return CHAR_FOUR;
    if (r < 54) return CHAR_H;
    if (r < 80) return CLASS_BITS'("0" + $urandom_range(9));
    return CLASS_BITS'($urandom);
  endfunction

  function automatic det_t noise_det();
    det_t d;
    d.box_x      = COORD_BITS'($urandom);
    d.box_y      = COORD_BITS'($urandom);
    d.box_w      = COORD_BITS'($urandom);
    d.box_h      = COORD_BITS'($urandom);
    d.score      = SCORE_BITS'($urandom);
    d.class_code = CLASS_BITS'($urandom);
    d.last       = 1'($urandom_range(1));
    return d;
  endfunction

  // Neighbor of the previous box in the list: shifted right, similar size.
  function automatic det_t neighbor_det(input det_t prev);
    det_t d;
    d = prev;
    d.box_x = COORD_BITS'(int'(prev.box_x) + $urandom_range(int'(prev.box_w) / 2 + 2));
    d.box_y = COORD_BITS'(int'(prev.box_y) + $urandom_range(4) - 2);
    d.box_w = COORD_BITS'(int'(prev.box_w) + $urandom_range(6) - 3);
    d.box_h = COORD_BITS'(int'(prev.box_h) + $urandom_range(6) - 3);
    return d;
  endfunction

  task automatic queue_random_lists(input int count);
    det_t d, prev;
    int   left, run;
    left = count;
    prev = '0;
    while (left > 0) begin
      if ($urandom_range(99) < 15) begin
        detections_to_send.insert(detections_to_send.size(), noise_det());
        left--;
      end else begin
        run = $urandom_range(1, 12);
        if (run > left) run = left;
        for (int k = 0; k < run; k++) begin
          if (k == 0 || $urandom_range(99) < 15) begin
            d.box_x = COORD_BITS'($urandom);
            d.box_y = COORD_BITS'($urandom);
            d.box_w = pick_size();
            d.box_h = pick_size();
          end else begin
            d = neighbor_det(prev);
          end
          d.score      = pick_score(prev.score);
          d.class_code = pick_class();
          d.last       = (k == run - 1);
          detections_to_send.insert(detections_to_send.size(), d);
          prev = d;
          left--;
        end
      end
    end
  endtask

  initial begin
    rst          <= 1'b1;
    cfg_write    <= 1'b0;
    cfg_index    <= '0;
    cfg_data     <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed lists under the reset settings.
    push_det(100, 100, 20, 30, 30000, "A", 1'b0);
    push_det(100, 100, 20, 30, 40000, "B", 1'b0);           // full overlap, held weaker
    push_det(100, 100, 20, 30, 40000, "C", 1'b0);           // score tie drops the new box
    push_det(3000, 100, 10, 10, 100, "D", 1'b0);            // no overlap, B goes out
    push_det(3005, 100, 10, 10, 20000, "E", 1'b0);          // between tolerances, weak held
    push_det(3010, 100, 10, 10, 50, "F", 1'b0);             // between tolerances, weak new
    push_det(3010, 100, 10, 10, 20000, "G", 1'b0);          // between tolerances, tie
    push_det(3013, 100, 10, 10, 50000, CHAR_ONE, 1'b0);     // digit one raises tolerance
    push_det(3016, 100, 10, 10, 60000, CHAR_SEVEN, 1'b0);   // one next to seven is ambiguous
    push_det(3019, 100, 10, 10, 10, CHAR_ONE, 1'b0);
    push_det(0, 0, 0, 0, 0, 8'd0, 1'b0);
    push_det(0, 0, 0, 5, 65535, 8'd255, 1'b0);              // zero union
    push_det(4095, 4095, 4095, 4095, 65535, CHAR_ONE, 1'b1); // two survivors from one item
    push_det(4095, 4095, 4095, 4095, 0, CHAR_FOUR, 1'b1);   // single-item list
    push_det(4000, 4000, 4095, 4095, 65535, "Z", 1'b0);
    push_det(4001, 4001, 4095, 4095, 0, CHAR_ONE, 1'b1);    // huge boxes, new dropped, flush
    push_det(200, 200, 8, 8, 1000, CHAR_H, 1'b0);
    push_det(200, 200, 8, 8, 2000, CHAR_ONE, 1'b1);         // one next to H is ambiguous
    push_det(500, 500, 10, 10, 13107, "x", 1'b0);
    push_det(505, 500, 10, 10, 13106, "y", 1'b1);           // just below the weak limit
    push_det(500, 500, 10, 10, 13106, "x", 1'b0);
    push_det(505, 500, 10, 10, 13107, "y", 1'b1);
    wait_drained();

    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: load_settings(127, 127, 127, 0);
        1: load_settings(0, 0, 0, 65535);
        2: load_settings(100, 100, 100, $urandom_range(65535));
        3: load_settings($urandom_range(127), $urandom_range(127), $urandom_range(127),
                         $urandom_range(65535));
        4: load_settings(20, 60, 5, 40000);
        default: load_settings(int'(TOL_HIGH_RESET), int'(TOL_LOW_RESET), int'(TOL_ONE_RESET),
                               int'(WEAK_SCORE_RESET));
      endcase
      no_idle = (p == 2);
      queue_random_lists(PHASE_ITEMS);
      wait_drained();
    end

    mismatches += survivors_due.size();
    if (mismatches == 0) begin
      $display("PASS adjacent_box_overlap_suppression_top");
    end else begin
      $display("FAIL adjacent_box_overlap_suppression_top");
    end
    $finish;
  end

endmodule
